// ----- hdl/pol_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pol_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned OpW = 4;
  localparam int unsigned PosW = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FoundW = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_INSERT_AT    = 4'd0,
    OP_INSERT_FRONT = 4'd1,
    OP_INSERT_BACK  = 4'd2,
    OP_DELETE_AT    = 4'd3,
    OP_DELETE_FRONT = 4'd4,
    OP_DELETE_BACK  = 4'd5,
    OP_SEARCH       = 4'd6,
    OP_REVERSE      = 4'd7,
    OP_MIDDLE       = 4'd8,
    OP_CLEAR        = 4'd9
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;       // capture request and decide
    logic rd_wp;      // read RAM at write pointer instead of read pointer
    logic wr_shift;   // write last read data at write pointer (shift step)
    logic wr_val;     // write request value at write pointer
    logic wr_swap;    // write held data at write pointer (reverse step)
    logic wr_lo;      // write last read data at read pointer (reverse step)
    logic step;       // advance pointers
    logic cmp;        // compare RAM data with key
    logic grab_mid;   // capture RAM data as middle value
    logic hold_a;     // hold RAM data in swap register
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic [2:0] kind; // 0 done now,1 shift up,2 shift down,3 search,4 reverse,5 middle
    logic       walk_done;
    logic       hit;
  } sts_t;

  localparam logic [2:0] K_DONE = 3'd0;
  localparam logic [2:0] K_UP   = 3'd1;
  localparam logic [2:0] K_DOWN = 3'd2;
  localparam logic [2:0] K_SRCH = 3'd3;
  localparam logic [2:0] K_REV  = 3'd4;
  localparam logic [2:0] K_MID  = 3'd5;

endpackage
`default_nettype wire

// ----- hdl/pol_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pol_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/pol_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pol_datapath #(
  parameter int unsigned Capacity = pol_pkg::Capacity
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [pol_pkg::OpW-1:0]      op_i,
  input  wire logic [pol_pkg::ValueW-1:0]   value_i,
  input  wire logic [pol_pkg::PosW-1:0]     position_i,
  input  wire pol_pkg::cmd_t                cmd_i,
  output pol_pkg::sts_t                     sts_o,
  output logic [pol_pkg::StatusW-1:0]       status_o,
  output logic [pol_pkg::FoundW-1:0]        found_o,
  output logic [pol_pkg::ValueW-1:0]        middle_o,
  output logic [pol_pkg::CountW-1:0]        count_o
);
  import pol_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rp_q, rp_d, wp_q, wp_d, lim_q, lim_d;
  logic [ValueW-1:0] key_q, hold_q;
  logic [2:0] kind_q, kind_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [CW-1:0] fidx_q;
  logic [ValueW-1:0] mid_q;
  logic [ValueW-1:0] rdata;
  logic we, hit;
  logic [AW-1:0] waddr, raddr;
  logic [ValueW-1:0] wdata;
  logic [PW-1:0] pos_w, cnt_w;
  logic full, empty;

  assign pos_w = PW'(position_i);
  assign cnt_w = PW'(count_q);
  assign full  = (count_q == CW'(Capacity));
  assign empty = (count_q == '0);
  assign hit   = (rdata == key_q);

  pol_ram #(.Width(ValueW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = cmd_i.rd_wp ? wp_q[AW-1:0] : rp_q[AW-1:0];
  assign waddr = cmd_i.wr_lo ? rp_q[AW-1:0] : wp_q[AW-1:0];
  assign we    = cmd_i.wr_shift | cmd_i.wr_val | cmd_i.wr_swap | cmd_i.wr_lo;
  always_comb begin
    if (cmd_i.wr_val)       wdata = key_q;
    else if (cmd_i.wr_swap) wdata = hold_q;
    else                    wdata = rdata;
  end

  // Decode kind, pointers, count, early status; or step pointers.
  always_comb begin
    rp_d = rp_q; wp_d = wp_q; lim_d = lim_q; count_d = count_q;
    kind_d = kind_q; st_d = st_q;
    if (cmd_i.load) begin
      kind_d = K_DONE; st_d = ST_OK;
      unique case (op_i)
        OP_INSERT_AT, OP_INSERT_FRONT, OP_INSERT_BACK: begin
          if (op_i == OP_INSERT_AT && pos_w > cnt_w) st_d = ST_BAD_POS;
          else if (full) st_d = ST_FULL;
          else begin
            kind_d  = K_UP;
            count_d = count_q + CW'(1);
            // Shift [p, count) up by one, reading from the top.
            rp_d = count_q - CW'(1);
            wp_d = count_q;
            if (op_i == OP_INSERT_AT)         lim_d = CW'(position_i);
            else if (op_i == OP_INSERT_FRONT) lim_d = '0;
            else                              lim_d = count_q;
          end
        end
        OP_DELETE_AT, OP_DELETE_FRONT, OP_DELETE_BACK: begin
          if (op_i == OP_DELETE_AT && pos_w > cnt_w) st_d = ST_BAD_POS;
          else if (empty) st_d = ST_EMPTY;
          else if (op_i == OP_DELETE_AT && pos_w == cnt_w) st_d = ST_BAD_POS;
          else begin
            kind_d  = K_DOWN;
            count_d = count_q - CW'(1);
            // Shift (p, count) down by one.
            lim_d = count_q;
            if (op_i == OP_DELETE_AT) begin
              wp_d = CW'(position_i); rp_d = CW'(position_i) + CW'(1);
            end else if (op_i == OP_DELETE_FRONT) begin
              wp_d = '0; rp_d = CW'(1);
            end else begin
              wp_d = count_q - CW'(1); rp_d = count_q;
            end
          end
        end
        OP_SEARCH: begin
          if (empty) st_d = ST_EMPTY;
          else begin
            kind_d = K_SRCH; st_d = ST_NOT_FOUND; rp_d = '0; lim_d = count_q;
          end
        end
        OP_REVERSE: begin
          if (empty) st_d = ST_EMPTY;
          else begin kind_d = K_REV; rp_d = '0; wp_d = count_q - CW'(1); end
        end
        OP_MIDDLE: begin
          if (empty) st_d = ST_EMPTY;
          else begin kind_d = K_MID; rp_d = count_q >> 1; end
        end
        OP_CLEAR: count_d = '0;
        default: ;
      endcase
    end else if (cmd_i.step) begin
      unique case (kind_q)
        K_UP:    begin rp_d = rp_q - CW'(1); wp_d = wp_q - CW'(1); end
        K_DOWN:  begin rp_d = rp_q + CW'(1); wp_d = wp_q + CW'(1); end
        K_REV:   begin rp_d = rp_q + CW'(1); wp_d = wp_q - CW'(1); end
        default: rp_d = rp_q + CW'(1);
      endcase
    end
    if (cmd_i.cmp && hit) st_d = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kind_q  <= K_DONE;
      st_q    <= ST_OK;
      rp_q <= '0; wp_q <= '0; lim_q <= '0;
    end else begin
      count_q <= count_d;
      kind_q  <= kind_d;
      st_q    <= st_d;
      rp_q <= rp_d; wp_q <= wp_d; lim_q <= lim_d;
    end
  end

  // Payload captures.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= value_i;
      mid_q <= '0;
    end else if (cmd_i.grab_mid) begin
      mid_q <= rdata;
    end
    if (cmd_i.hold_a) hold_q <= rdata;
    // Search data lags the read pointer by one.
    if (cmd_i.load)             fidx_q <= '0;
    else if (cmd_i.cmp && hit)  fidx_q <= rp_q - CW'(1);
  end

  // Walk end tests per kind.
  always_comb begin
    sts_o.kind = kind_q;
    sts_o.hit  = hit;
    unique case (kind_q)
      K_UP:    sts_o.walk_done = (wp_q == lim_q);
      K_DOWN:  sts_o.walk_done = (rp_q >= lim_q);
      K_SRCH:  sts_o.walk_done = (rp_q >= lim_q);
      K_REV:   sts_o.walk_done = (rp_q >= wp_q);
      default: sts_o.walk_done = 1'b1;
    endcase
  end

  assign status_o = st_q;
  assign found_o  = FoundW'(fidx_q);
  assign middle_o = mid_q;
  assign count_o  = CountW'(count_q);
endmodule
`default_nettype wire

// ----- hdl/pol_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pol_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_fire_i,
  input  wire logic          out_busy_i,
  input  wire pol_pkg::sts_t sts_i,
  output pol_pkg::cmd_t      cmd_o,
  output logic               idle_o,
  output logic               done_o
);
  import pol_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_DEC    = 8'b00000010,
    S_RD     = 8'b00000100,
    S_USE    = 8'b00001000,
    S_RD2    = 8'b00010000,
    S_USE2   = 8'b00100000,
    S_INS    = 8'b01000000,
    S_FIN    = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // Sequence one request through its walk.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    idle_o  = 1'b0;
    done_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        cmd_o.load = in_fire_i;
        if (in_fire_i) state_d = S_DEC;
      end
      S_DEC: begin
        unique case (sts_i.kind)
          K_UP:    state_d = sts_i.walk_done ? S_INS : S_RD;
          K_DOWN, K_SRCH, K_REV: state_d = sts_i.walk_done ? S_FIN : S_RD;
          K_MID:   state_d = S_RD;
          default: state_d = S_FIN;
        endcase
      end
      S_RD: state_d = S_USE;
      S_USE: begin
        unique case (sts_i.kind)
          K_UP, K_DOWN: begin
            cmd_o.wr_shift = 1'b1;
            cmd_o.step     = 1'b1;
            state_d = S_DEC;
          end
          K_SRCH: begin
            cmd_o.step = 1'b1;
            state_d = S_RD2;
          end
          K_REV: begin
            // Hold the low entry, fetch the high one.
            cmd_o.hold_a = 1'b1;
            cmd_o.rd_wp  = 1'b1;
            state_d = S_RD2;
          end
          default: begin
            cmd_o.grab_mid = 1'b1;
            state_d = S_FIN;
          end
        endcase
      end
      S_RD2: begin
        if (sts_i.kind == K_SRCH) begin
          cmd_o.cmp = 1'b1;
          state_d = (sts_i.hit || sts_i.walk_done) ? S_FIN : S_RD;
        end else begin
          cmd_o.wr_lo = 1'b1;
          state_d = S_USE2;
        end
      end
      S_USE2: begin
        cmd_o.wr_swap = 1'b1;
        cmd_o.step    = 1'b1;
        state_d = S_DEC;
      end
      S_INS: begin
        cmd_o.wr_val = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_busy_i) begin
          done_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

// ----- hdl/positional_ordered_list_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Bounded ordered list of signed 32-bit values, one operation per request
// with one result each. A request is accepted only while the controller is
// idle, so one request is in flight at a time. Insert and delete walk the
// entries they move, search walks the entries it reads and reverse the
// pairs it swaps. The walks are set by the list RAM, which has one
// registered read port and one write port. A result the receiver has not
// taken holds the next request in its final state.
module positional_ordered_list_core #(
  parameter int unsigned Capacity = pol_pkg::Capacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // opcode[3:0], value[35:4], position[42:36]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // status[2:0], found[8:3], middle[40:9], count[47:41]
);
  import pol_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle, done, in_fire, out_busy;
  logic [StatusW-1:0] status;
  logic [FoundW-1:0]  found;
  logic [ValueW-1:0]  middle;
  logic [CountW-1:0]  count;
  logic               m_valid_q, m_valid_d;
  logic [47:0]        m_data_q, m_data_d;

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid & idle;
  assign out_busy      = m_valid_q & ~m_axis_tready;

  pol_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire), .out_busy_i(out_busy), .sts_i(sts),
    .cmd_o(cmd), .idle_o(idle), .done_o(done)
  );

  pol_datapath #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni,
    .op_i(s_axis_tdata[3:0]), .value_i(s_axis_tdata[35:4]),
    .position_i(s_axis_tdata[42:36]), .cmd_i(cmd), .sts_o(sts),
    .status_o(status), .found_o(found), .middle_o(middle), .count_o(count)
  );

  // Hold the result until taken; load a new one when the request finishes.
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;
    if (done) begin
      m_valid_d = 1'b1;
      m_data_d  = {count, middle, found, status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Result holds steady while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

  // Status code stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_NOT_FOUND);

  // Found index is zero unless the request succeeded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[8:3] == '0);
endmodule
`default_nettype wire
